@@ rtl/bpa_pkg.sv @@
// Shared constants, request kinds and search helper for the bitmap page allocator.
package bpa_pkg;

  localparam int MAX_PAGES  = 65536;
  localparam int PAGE_SHIFT = 12;

  localparam int PHYS_W = 48;
  localparam int ADDR_W = 28;
  localparam int CNT_W  = 17;

  // Page index split: group of words, word within group, bit within word.
  localparam int IDX_W   = $clog2(MAX_PAGES);
  localparam int WORD_W  = 64;
  localparam int BIT_W   = $clog2(WORD_W);
  localparam int WADDR_W = IDX_W - BIT_W;
  localparam int WORDS   = MAX_PAGES / WORD_W;
  localparam int WSEL_W  = 5;
  localparam int GRP_W   = 1 << WSEL_W;
  localparam int GADDR_W = WADDR_W - WSEL_W;
  localparam int GROUPS  = WORDS / GRP_W;

  localparam logic [CNT_W-1:0] COUNT_CAP =
    (MAX_PAGES < 'h1FFFF) ? CNT_W'(MAX_PAGES) : CNT_W'('h1FFFF);
  localparam logic [CNT_W-1:0] PAGES_MAX = CNT_W'(MAX_PAGES);

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_FREE    = 2'd1,
    KIND_MARK    = 2'd2,
    KIND_RESERVE = 2'd3
  } kind_t;

  // Position of the lowest set bit; zero when none is set.
  function automatic logic [BIT_W-1:0] first_set(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) pos = BIT_W'(i);
    end
    return pos;
  endfunction

endpackage

@@ rtl/bpa_ram.sv @@
// Simple dual-port synchronous RAM with registered read data.
module bpa_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/bitmap_page_allocator.sv @@
// Top level of the first-fit bitmap page frame allocator.
//
// One request beat in, one result beat out. The in-use bitmap lives in a
// 1024 x 64 RAM, with a 32 x 32 RAM of per-word "has a free page" bits and
// a 32-bit group summary in flops above it. A word whose summary bit is
// clear reads as all ones, so the bitmap needs no clearing pass after reset
// and requests are taken from the first cycle. Free, mark usable and
// reserve step through read, modify and write back, and load result;
// allocate adds an extra RAM read to walk from the group summary down to
// the bitmap word. One request is in flight at a time; a new one is
// accepted while the previous result still waits on the output, and a
// result that is not taken stalls the next request in its last cycle.
module bitmap_page_allocator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [bpa_pkg::CNT_W-1:0]   cfg_wr_data,   // total_pages
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [bpa_pkg::PHYS_W-1:0]  s_axis_tdata,  // phys_addr[47:0]
  input  logic [1:0]                  s_axis_tuser,  // kind[1:0]
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // page_addr[27:0], free_count[44:28], usable_count[61:45],
  // used_count[78:62], reserved_count[95:79]
  output logic [95:0]                 m_axis_tdata,
  output logic                        m_axis_tuser   // alloc_failed
);
  import bpa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_FIND,
    S_MOD,
    S_OUT
  } state_t;

  state_t             state;
  kind_t              kind_r;
  logic [IDX_W-1:0]   idx_r;
  logic               in_range;
  logic               fail_r;
  logic [GROUPS-1:0]  grp_bits;
  logic [CNT_W-1:0]   free_pages;
  logic [CNT_W-1:0]   usable_pages;
  logic [CNT_W-1:0]   total_pages;
  logic [ADDR_W-1:0]  res_addr;
  logic               res_failed;

  logic               accept;
  logic [GADDR_W-1:0] grp;
  logic [WSEL_W-1:0]  wsel;
  logic [BIT_W-1:0]   grp_pos;
  logic [BIT_W-1:0]   wsel_pos;
  logic [BIT_W-1:0]   bit_pos;
  logic [BIT_W-1:0]   free_pos;

  logic [GRP_W-1:0]   l1_rd;
  logic [GRP_W-1:0]   l1_eff;
  logic [GRP_W-1:0]   l1_new;
  logic [GADDR_W-1:0] l1_raddr;
  logic [WORD_W-1:0]  bm_rd;
  logic [WORD_W-1:0]  word_eff;
  logic [WORD_W-1:0]  word_new;
  logic [WORD_W-1:0]  bit_mask;
  logic [WADDR_W-1:0] bm_raddr;

  logic [IDX_W-1:0]   page;
  logic [CNT_W-1:0]   lim;
  logic               below;
  logic               old_bit;
  logic               do_set;
  logic               do_clr;
  logic               free_inc;
  logic               free_dec;
  logic               usable_inc;
  logic               alloc_ok;
  logic               wr_en;

  logic [CNT_W-1:0]   used_cnt;
  logic [CNT_W-1:0]   reserved_cnt;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);

  assign grp  = idx_r[IDX_W-1 -: GADDR_W];
  assign wsel = idx_r[BIT_W +: WSEL_W];

  // Lowest group with a free page, then lowest word within that group.
  assign grp_pos  = first_set(WORD_W'(grp_bits));
  assign l1_eff   = grp_bits[grp] ? l1_rd : '0;
  assign wsel_pos = first_set(WORD_W'(l1_eff));

  assign l1_raddr = (state == S_READ && kind_r == KIND_ALLOC) ?
                    grp_pos[GADDR_W-1:0] : grp;
  assign bm_raddr = (state == S_FIND) ? {grp, wsel_pos[WSEL_W-1:0]} :
                    idx_r[IDX_W-1 -: WADDR_W];

  bpa_ram #(.DEPTH(GROUPS), .WIDTH(GRP_W)) u_summary_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (grp),
    .wdata (l1_new),
    .raddr (l1_raddr),
    .rdata (l1_rd)
  );

  bpa_ram #(.DEPTH(WORDS), .WIDTH(WORD_W)) u_bitmap_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (idx_r[IDX_W-1 -: WADDR_W]),
    .wdata (word_new),
    .raddr (bm_raddr),
    .rdata (bm_rd)
  );

  // A word whose summary bit is clear has no free page: read it as all ones.
  assign word_eff = l1_eff[wsel] ? bm_rd : '1;
  assign free_pos = first_set(~word_eff);
  assign bit_pos  = (kind_r == KIND_ALLOC) ? free_pos : idx_r[BIT_W-1:0];
  assign page     = {idx_r[IDX_W-1 -: WADDR_W], bit_pos};
  assign bit_mask = WORD_W'(1) << bit_pos;
  assign old_bit  = word_eff[bit_pos];

  assign lim      = (total_pages > PAGES_MAX) ? PAGES_MAX : total_pages;
  assign below    = {1'b0, page} < lim;
  assign alloc_ok = !fail_r && below;

  always_comb begin
    do_set     = 1'b0;
    do_clr     = 1'b0;
    free_inc   = 1'b0;
    free_dec   = 1'b0;
    usable_inc = 1'b0;
    unique case (kind_r)
      KIND_ALLOC: begin
        do_set   = alloc_ok;
        free_dec = alloc_ok;
      end
      KIND_FREE: begin
        do_clr   = in_range && below && old_bit;
        free_inc = in_range && below && old_bit;
      end
      KIND_MARK: begin
        do_clr     = in_range;
        usable_inc = in_range;
        free_inc   = in_range && old_bit && below;
      end
      KIND_RESERVE: begin
        do_set   = in_range;
        free_dec = in_range && !old_bit && below;
      end
      default: ;
    endcase
  end

  assign wr_en    = (state == S_MOD) && (do_set || do_clr);
  assign word_new = do_set ? (word_eff | bit_mask) :
                    do_clr ? (word_eff & ~bit_mask) : word_eff;

  always_comb begin
    l1_new       = l1_eff;
    l1_new[wsel] = ~&word_new;
  end

  assign used_cnt     = (usable_pages > free_pages) ? usable_pages - free_pages : '0;
  assign reserved_cnt = (total_pages > usable_pages) ? total_pages - usable_pages : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      kind_r        <= KIND_ALLOC;
      grp_bits      <= '0;
      free_pages    <= '0;
      usable_pages  <= '0;
      total_pages   <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) total_pages <= cfg_wr_data;
      // A result loaded in S_OUT replaces the beat that leaves.
      if (m_axis_tvalid && m_axis_tready && state != S_OUT) m_axis_tvalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            kind_r   <= kind_t'(s_axis_tuser);
            idx_r    <= s_axis_tdata[PAGE_SHIFT +: IDX_W];
            in_range <= (s_axis_tdata[PHYS_W-1:PAGE_SHIFT+IDX_W] == '0);
            state    <= S_READ;
          end
        end
        S_READ: begin
          if (kind_r == KIND_ALLOC) begin
            // Hold the group; the word and bit fields follow.
            fail_r <= (grp_bits == '0);
            idx_r  <= {grp_pos[GADDR_W-1:0], {(WSEL_W+BIT_W){1'b0}}};
            state  <= S_FIND;
          end else begin
            fail_r <= 1'b0;
            state  <= S_MOD;
          end
        end
        S_FIND: begin
          idx_r[BIT_W +: WSEL_W] <= wsel_pos[WSEL_W-1:0];
          state                  <= S_MOD;
        end
        S_MOD: begin
          if (wr_en) grp_bits[grp] <= |l1_new;
          if (free_inc && free_pages < COUNT_CAP) free_pages <= free_pages + 1'b1;
          if (free_dec && free_pages != '0) free_pages <= free_pages - 1'b1;
          if (usable_inc && usable_pages < COUNT_CAP) usable_pages <= usable_pages + 1'b1;
          res_addr   <= (kind_r == KIND_ALLOC && alloc_ok) ?
                        ADDR_W'({page, {PAGE_SHIFT{1'b0}}}) : '0;
          res_failed <= (kind_r == KIND_ALLOC) && !alloc_ok;
          state      <= S_OUT;
        end
        S_OUT: begin
          // Wait for the output register to drain.
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {reserved_cnt, used_cnt, usable_pages, free_pages, res_addr};
            m_axis_tuser  <= res_failed;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_starts_read: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_READ)
    else $error("accepted request did not start a read");

  a_alloc_word_has_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD && kind_r == KIND_ALLOC && !fail_r) |-> (word_eff != '1))
    else $error("summary points at a word with no free page");

  a_counts_capped: assert property (@(posedge clk) disable iff (rst)
    (free_pages <= COUNT_CAP) && (usable_pages <= COUNT_CAP))
    else $error("page counter above cap");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[ADDR_W-1:0] == '0))
    else $error("failed allocate carries a page address");

  a_summary_follows_write: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> grp_bits[$past(grp)] == $past(|l1_new))
    else $error("group summary not updated");

endmodule

@@ bench/bpa_result_checker.sv @@
// Scoreboard for the bitmap page allocator: mirrors the page bitmap and checks every result beat.
module bpa_result_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [bpa_pkg::CNT_W-1:0]  cfg_wr_data,
  input  logic                       s_axis_tvalid,
  input  logic                       s_axis_tready,
  input  logic [bpa_pkg::PHYS_W-1:0] s_axis_tdata,
  input  logic [1:0]                 s_axis_tuser,
  input  logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic [95:0]                m_axis_tdata,
  input  logic                       m_axis_tuser,
  output int                         error_count,
  output int                         pending,
  output int                         result_count,
  output int                         alloc_hits,
  output int                         alloc_misses
);
  timeunit 1ns;
  timeprecision 1ps;
  import bpa_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] page_addr;
    logic              alloc_failed;
    logic [CNT_W-1:0]  free_cnt;
    logic [CNT_W-1:0]  usable_cnt;
    logic [CNT_W-1:0]  used_cnt;
    logic [CNT_W-1:0]  reserved_cnt;
  } page_status_t;

  bit            page_used [MAX_PAGES];
  int unsigned   free_pages;
  int unsigned   usable_pages;
  int unsigned   total_reg;
  page_status_t  status_fifo [$];
  int            mismatches;
  int            results_seen;
  int            hits;
  int            misses;

  task automatic count_up(inout int unsigned c);
    if (c < COUNT_CAP) c++;
  endtask

  task automatic count_down(inout int unsigned c);
    if (c > 0) c--;
  endtask

  // Apply one request to the mirrored state and build the status it returns.
  task automatic serve_request(input kind_t k, input logic [PHYS_W-1:0] pa,
                               output page_status_t st);
    longint unsigned pg;
    longint unsigned lim;
    pg  = pa >> PAGE_SHIFT;
    lim = (total_reg < MAX_PAGES) ? total_reg : MAX_PAGES;
    st  = '0;
    case (k)
      KIND_ALLOC: begin
        st.alloc_failed = 1'b1;
        for (int i = 0; i < lim; i++) begin
          if (!page_used[i]) begin
            page_used[i] = 1'b1;
            count_down(free_pages);
            st.page_addr    = ADDR_W'(longint'(i) << PAGE_SHIFT);
            st.alloc_failed = 1'b0;
            break;
          end
        end
      end
      KIND_FREE: begin
        if (pg < lim && page_used[pg]) begin
          page_used[pg] = 1'b0;
          count_up(free_pages);
        end
      end
      KIND_MARK: begin
        if (pg < MAX_PAGES) begin
          // free count follows clear bits only inside the managed range
          if (page_used[pg] && pg < lim) count_up(free_pages);
          page_used[pg] = 1'b0;
          count_up(usable_pages);
        end
      end
      default: begin
        if (pg < MAX_PAGES) begin
          if (!page_used[pg] && pg < lim) count_down(free_pages);
          page_used[pg] = 1'b1;
        end
      end
    endcase
    st.free_cnt     = CNT_W'(free_pages);
    st.usable_cnt   = CNT_W'(usable_pages);
    st.used_cnt     = (usable_pages > free_pages) ? CNT_W'(usable_pages - free_pages) : '0;
    st.reserved_cnt = (total_reg > usable_pages) ? CNT_W'(total_reg - usable_pages) : '0;
  endtask

  task automatic check_field(input string name, input longint unsigned exp_v,
                             input longint unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    page_status_t exp_st;
    page_status_t act_st;
    if (rst) begin
      foreach (page_used[i]) page_used[i] = 1'b1;
      free_pages   = 0;
      usable_pages = 0;
      total_reg    = 0;
      status_fifo.delete();
    end else begin
      if (cfg_wr_en) total_reg = cfg_wr_data;
      // retire the oldest expectation before taking a new request beat
      if (m_axis_tvalid && m_axis_tready) begin
        act_st.page_addr    = m_axis_tdata[27:0];
        act_st.alloc_failed = m_axis_tuser;
        act_st.free_cnt     = m_axis_tdata[44:28];
        act_st.usable_cnt   = m_axis_tdata[61:45];
        act_st.used_cnt     = m_axis_tdata[78:62];
        act_st.reserved_cnt = m_axis_tdata[95:79];
        if (status_fifo.size() == 0) begin
          $display("%0t: result beat with nothing expected, expected none, got %h/%b",
                   $time, m_axis_tdata, m_axis_tuser);
          mismatches++;
        end else begin
          exp_st = status_fifo.pop_front();
          check_field("page_addr", exp_st.page_addr, act_st.page_addr);
          check_field("alloc_failed", exp_st.alloc_failed, act_st.alloc_failed);
          check_field("free_count", exp_st.free_cnt, act_st.free_cnt);
          check_field("usable_count", exp_st.usable_cnt, act_st.usable_cnt);
          check_field("used_count", exp_st.used_cnt, act_st.used_cnt);
          check_field("reserved_count", exp_st.reserved_cnt, act_st.reserved_cnt);
          results_seen++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        serve_request(kind_t'(s_axis_tuser), s_axis_tdata, exp_st);
        status_fifo.push_back(exp_st);
        if (kind_t'(s_axis_tuser) == KIND_ALLOC) begin
          if (exp_st.alloc_failed) misses++;
          else hits++;
        end
      end
    end
    error_count  <= mismatches;
    pending      <= status_fifo.size();
    result_count <= results_seen;
    alloc_hits   <= hits;
    alloc_misses <= misses;
  end

endmodule

@@ bench/bitmap_page_allocator_test.sv @@
// Top of the bitmap page allocator bench: clock, reset, request stimulus and verdict.
module bitmap_page_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bpa_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 200;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [CNT_W-1:0]  cfg_wr_data = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [PHYS_W-1:0] s_axis_tdata = '0;   // phys_addr[47:0]
  logic [1:0]        s_axis_tuser = '0;   // kind[1:0]
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // page_addr[27:0], free_count[44:28], usable_count[61:45],
  // used_count[78:62], reserved_count[95:79]
  logic [95:0]       m_axis_tdata;
  logic              m_axis_tuser;        // alloc_failed

  int error_count;
  int pending;
  int result_count;
  int alloc_hits;
  int alloc_misses;
  int src_idle = 0;
  int dst_idle = 0;
  int sent_count = 0;
  int cycle_count = 0;

  bitmap_page_allocator i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  bpa_result_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .error_count   (error_count),
    .pending       (pending),
    .result_count  (result_count),
    .alloc_hits    (alloc_hits),
    .alloc_misses  (alloc_misses)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL bitmap_page_allocator");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= dst_idle);
  end

  // Hold valid high until the beat is taken; leave it high for a following beat.
  task automatic send_req(input kind_t k, input logic [PHYS_W-1:0] pa);
    if ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pa;
    s_axis_tuser  <= k;
    do @(posedge clk); while (!s_axis_tready);
    sent_count++;
  endtask

  // Stop sending and wait for every outstanding result.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_total(input int unsigned pages);
    drain();
    repeat (8) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CNT_W'(pages);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [PHYS_W-1:0] page_phys(input int unsigned pg);
    return (PHYS_W'(pg) << PAGE_SHIFT) | PHYS_W'($urandom_range(4095));
  endfunction

  // Bias page picks toward low pages and the edge of the managed range.
  function automatic logic [PHYS_W-1:0] pick_phys(input int lim);
    int r;
    int pg;
    r = $urandom_range(99);
    if (r >= 92) return PHYS_W'({$urandom, $urandom});
    if (r < 60) pg = $urandom_range(63);
    else if (r < 80) pg = lim + int'($urandom_range(8)) - 4;
    else pg = $urandom_range(MAX_PAGES - 1);
    if (pg < 0) pg = 0;
    if (pg > MAX_PAGES - 1) pg = MAX_PAGES - 1;
    return page_phys(pg);
  endfunction

  function automatic kind_t pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 30) return KIND_ALLOC;
    if (r < 55) return KIND_FREE;
    if (r < 85) return KIND_MARK;
    return KIND_RESERVE;
  endfunction

  initial begin
    int unsigned phase_total [6];
    int lim;
    phase_total = '{64, 0, 65536, 1, 300, 4096};
    src_idle = 35;
    dst_idle = 72;
    while (rst) @(posedge clk);

    // page count still zero after reset
    send_req(KIND_ALLOC, '0);
    send_req(KIND_MARK, page_phys(0));
    send_req(KIND_FREE, page_phys(0));
    send_req(KIND_RESERVE, '1);
    send_req(KIND_MARK, '1);

    // full range; page 0 is already clear but not counted free
    set_total(MAX_PAGES);
    send_req(KIND_ALLOC, '1);
    send_req(KIND_MARK, page_phys(1));
    send_req(KIND_MARK, page_phys(MAX_PAGES - 1));
    send_req(KIND_MARK, page_phys(1));
    send_req(KIND_ALLOC, '0);
    send_req(KIND_ALLOC, '0);
    send_req(KIND_ALLOC, '0);
    send_req(KIND_FREE, page_phys(1));
    send_req(KIND_FREE, page_phys(1));
    for (int pg = 5; pg <= 8; pg++) send_req(KIND_FREE, page_phys(pg));
    send_req(KIND_RESERVE, page_phys(1));
    send_req(KIND_RESERVE, page_phys(1));
    send_req(KIND_FREE, PHYS_W'(1) << (PHYS_W - 1));
    send_req(KIND_ALLOC, '0);

    // shrink below the usable count
    set_total(2);
    send_req(KIND_ALLOC, '0);
    send_req(KIND_MARK, page_phys(3));
    send_req(KIND_FREE, page_phys(3));
    send_req(KIND_RESERVE, page_phys(6));

    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin
          src_idle = 35;
          dst_idle = 72;
        end
        1: begin
          src_idle = 72;
          dst_idle = 35;
        end
        default: begin
          src_idle = 0;
          dst_idle = 0;
        end
      endcase
      set_total(phase_total[phase]);
      lim = (phase_total[phase] < MAX_PAGES) ? phase_total[phase] : MAX_PAGES;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 97 == 50) drain();
        send_req(pick_kind(), pick_phys(lim));
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d requests over 8 page-count settings from 0 to %0d pages.",
             sent_count, MAX_PAGES);
    $display("Checked %0d results: %0d allocations granted, %0d refused.",
             result_count, alloc_hits, alloc_misses);
    if (error_count == 0 && pending == 0) begin
      $display("PASS bitmap_page_allocator");
    end else begin
      $display("FAIL bitmap_page_allocator");
    end
    $finish;
  end

endmodule
